[src/utf8d_pkg.sv]
// shared types and constants of the utf-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CP_W        = 21;
    localparam int unsigned BATCH_MAX   = 4;
    localparam int unsigned FIFO_DEPTH  = 8;
    localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned BATCH_CW    = $clog2(BATCH_MAX + 1);

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_BOM         = 21'h00FEFF;
    localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;

    // pending sequence length, none when idle
    typedef enum logic [2:0] {
        SEQ_NONE = 3'd0,
        SEQ_2    = 3'd2,
        SEQ_3    = 3'd3,
        SEQ_4    = 3'd4
    } t_seq_len;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
    } t_result;

    // all results caused by one input item
    typedef struct packed {
        logic [BATCH_CW-1:0]         count;
        t_result [BATCH_MAX-1:0]     item;
    } t_batch;

    function automatic t_seq_len lead_len(input logic [7:0] b);
        t_seq_len len;
        len = SEQ_NONE;
        if (b[7:5] == 3'b110) begin
            len = SEQ_2;
        end else if (b[7:4] == 4'b1110) begin
            len = SEQ_3;
        end else if (b[7:3] == 5'b11110) begin
            len = SEQ_4;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[src/utf8d_decoder.sv]
// sequence state and per-byte decode into a batch of results
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decoder
    import utf8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_string_end,
    output t_batch          o_batch
);

    t_seq_len    r_exp, n_exp;
    logic [1:0]  r_held, n_held;
    logic [7:0]  r_hold0, r_hold1, r_hold2;
    logic [7:0]  n_hold0, n_hold1, n_hold2;
    logic        r_at_start, n_at_start;

    logic            pend;
    logic            cont;
    logic [1:0]      k1;
    logic [1:0]      k2;
    logic            mid_en;
    t_result         mid;
    t_result         rep;
    logic [CP_W-1:0] cp;
    logic            bad;
    t_seq_len        st_len;
    logic [BATCH_CW-1:0] cnt;

    always_comb begin
        n_exp      = r_exp;
        n_held     = r_held;
        n_hold0    = r_hold0;
        n_hold1    = r_hold1;
        n_hold2    = r_hold2;
        n_at_start = r_at_start;
        k1         = 2'd0;
        k2         = 2'd0;
        mid_en     = 1'b0;
        rep        = '{code_point: CP_REPLACEMENT, replaced: 1'b1, last_of_run: 1'b0};
        mid        = rep;
        cp         = '0;
        bad        = 1'b0;
        pend       = (r_exp != SEQ_NONE);
        cont       = (i_byte_in[7:6] == 2'b10);
        st_len     = lead_len(i_byte_in);

        if (pend && cont) begin
            if (({1'b0, r_held} + 3'd1) >= 3'(r_exp)) begin
                unique case (r_exp)
                    SEQ_2: begin
                        cp  = {10'd0, r_hold0[4:0], i_byte_in[5:0]};
                        bad = (cp < CP_MIN_2);
                    end
                    SEQ_3: begin
                        cp  = {5'd0, r_hold0[3:0], r_hold1[5:0], i_byte_in[5:0]};
                        bad = (cp < CP_MIN_3) || ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
                    end
                    SEQ_4: begin
                        cp  = {r_hold0[2:0], r_hold1[5:0], r_hold2[5:0], i_byte_in[5:0]};
                        bad = (cp < CP_MIN_4) || (cp > CP_MAX);
                    end
                    default: begin
                        cp  = '0;
                        bad = 1'b0;
                    end
                endcase
                if (bad) begin
                    mid_en = 1'b1;
                end else if (!((cp == CP_BOM) && r_at_start)) begin
                    mid_en = 1'b1;
                    mid    = '{code_point: cp, replaced: 1'b0, last_of_run: 1'b0};
                end
                n_exp      = SEQ_NONE;
                n_held     = 2'd0;
                n_at_start = 1'b0;
            end else begin
                unique case (r_held)
                    2'd1:    n_hold1 = i_byte_in;
                    2'd2:    n_hold2 = i_byte_in;
                    default: n_hold0 = i_byte_in;
                endcase
                n_held = r_held + 2'd1;
            end
        end else begin
            // no sequence pending or not a continuation: flush any held bytes, then restart on this byte
            if (pend) begin
                k1         = r_held;
                n_at_start = 1'b0;
            end
            if (!i_byte_in[7]) begin
                mid_en     = 1'b1;
                mid        = '{code_point: {13'd0, i_byte_in}, replaced: 1'b0,
                               last_of_run: 1'b0};
                n_at_start = 1'b0;
                n_exp      = SEQ_NONE;
                n_held     = 2'd0;
            end else if (st_len == SEQ_NONE) begin
                mid_en     = 1'b1;
                n_at_start = 1'b0;
                n_exp      = SEQ_NONE;
                n_held     = 2'd0;
            end else begin
                n_hold0 = i_byte_in;
                n_held  = 2'd1;
                n_exp   = st_len;
            end
        end

        if (i_string_end) begin
            if (n_exp != SEQ_NONE) begin
                k2     = n_held;
                n_exp  = SEQ_NONE;
                n_held = 2'd0;
            end
            n_at_start = 1'b1;
        end

        cnt = BATCH_CW'(k1) + BATCH_CW'(mid_en) + BATCH_CW'(k2);
        o_batch.count = cnt;
        for (int i = 0; i < BATCH_MAX; i++) begin
            o_batch.item[i] = (mid_en && (BATCH_CW'(i) == BATCH_CW'(k1))) ? mid : rep;
            o_batch.item[i].last_of_run = (BATCH_CW'(i) == (cnt - BATCH_CW'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp      <= SEQ_NONE;
            r_held     <= 2'd0;
            r_at_start <= 1'b1;
        end else if (i_accept) begin
            r_exp      <= n_exp;
            r_held     <= n_held;
            r_at_start <= n_at_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hold0 <= n_hold0;
            r_hold1 <= n_hold1;
            r_hold2 <= n_hold2;
        end
    end

endmodule

`default_nettype wire

[src/utf8d_result_fifo.sv]
// result queue: takes a whole batch per cycle, gives one result per cycle while the reader is ready
`timescale 1ns / 1ps
`default_nettype none

module utf8d_result_fifo
    import utf8d_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_batch      i_batch,
    output logic        o_space_ok,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_result     o_item
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;
    logic [BATCH_CW-1:0]  push_n;

    assign o_valid    = (r_count != '0);
    assign o_item     = r_mem[r_rd];
    assign o_space_ok = (r_count <= FIFO_CW'(FIFO_DEPTH - BATCH_MAX));
    assign pop        = o_valid && i_ready;
    assign push_n     = i_push ? i_batch.count : '0;

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(push_n);
        n_rd    = r_rd + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < BATCH_MAX; k++) begin
            if (i_push && (BATCH_CW'(k) < i_batch.count)) begin
                r_mem[r_wr + FIFO_AW'(k)] <= i_batch.item[k];
            end
        end
    end

endmodule

`default_nettype wire

[src/utf8_stream_decoder.sv]
// top level of the utf-8 stream decoder
//
// input channel: one raw byte per item (i_byte_in) with i_string_end set on
// the last byte of a string, moved by i_in_valid / o_in_ready
// output channel: one code point per item (o_code_point, o_replaced,
// o_last_of_run), moved by o_out_valid / i_out_ready
// each input byte gives zero to four results; o_last_of_run marks the last
// result caused by a byte, so a byte with no results (held continuation,
// dropped byte order mark) shows nothing on the output
// results of an accepted byte go into the registered result queue at the
// accepting clock edge; an empty queue offers the first in the cycle after
// throughput: one byte per cycle while o_in_ready is high; the decode of a
// byte is a single combinational pass against the sequence state, and its
// results fill an eight-entry result queue that drains one per ready cycle
// o_in_ready comes from the registered queue fill alone (room for four
// results), so a stalled receiver lets the queue fill and then holds off
// input, with no path from i_out_ready to o_in_ready
// reset (i_rst_n low at a clock edge) empties the queue, drops any pending
// sequence and treats the next byte as the start of a string
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_byte_in,
    input  wire logic            i_string_end,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [CP_W-1:0]      o_code_point,
    output logic                 o_replaced,
    output logic                 o_last_of_run
);

    logic    accept;
    logic    space_ok;
    t_batch  batch;
    t_result head;

    // item taken only when the queue can hold a full batch
    assign o_in_ready = space_ok;
    assign accept     = i_in_valid && space_ok;

    utf8d_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_in    (i_byte_in),
        .i_string_end (i_string_end),
        .o_batch      (batch)
    );

    utf8d_result_fifo u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_batch    (batch),
        .o_space_ok (space_ok),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (head)
    );

    // result fields straight from the queue head
    assign o_code_point  = head.code_point;
    assign o_replaced    = head.replaced;
    assign o_last_of_run = head.last_of_run;

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the utf-8 stream decoder, with its own decode predictor
`timescale 1ns / 1ps

module tb_top;
    import utf8d_pkg::*;

    // clock, reset and the two channels, every input known from time zero
    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    logic [7:0]      in_byte   = 8'h00;
    logic            in_end    = 1'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [CP_W-1:0] out_cp;
    logic            out_rep;
    logic            out_last;

    utf8_stream_decoder DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_byte_in    (in_byte),
        .i_string_end (in_end),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_code_point (out_cp),
        .o_replaced   (out_rep),
        .o_last_of_run(out_last)
    );

    always #10 clk = ~clk;

    // decoder state as the predictor sees it, starting from the reset state
    t_seq_len   seq_len  = SEQ_NONE;
    int         held_n   = 0;
    logic [7:0] held_b [3];
    logic       at_start = 1'b1;

    t_result    byte_results[$];   // results of the byte being predicted
    t_result    cp_expected[$];    // code points still owed by the block
    logic [7:0] str_bytes[$];      // random string under construction

    // idling control shared by sender and receiver
    logic       steady  = 1'b0;    // no random gaps on either side while set
    int         rx_hold = 0;       // one long receiver hold-off, in cycles

    int errors         = 0;
    int bytes_sent     = 0;
    int strings_sent   = 0;
    int results_seen   = 0;
    int subs_seen      = 0;
    int input_stalls   = 0;

    function automatic int pick_gap();
        return steady ? 0 : int'($urandom_range(0, 17));
    endfunction

    // value in [lo, hi] leaning towards both ends of the range
    function automatic int pick_edge(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return int'($urandom_range(lo, hi));
    endfunction

    function automatic void note_result(input logic [CP_W-1:0] cp, input logic rep);
        t_result r;
        r.code_point  = cp;
        r.replaced    = rep;
        r.last_of_run = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // one substitute for the lead byte and one for each continuation held
    function automatic void flush_sequence();
        repeat (held_n) note_result(CP_REPLACEMENT, 1'b1);
        seq_len  = SEQ_NONE;
        held_n   = 0;
        at_start = 1'b0;
    endfunction

    // predicts the results of one accepted byte and queues them
    function automatic void decode_byte(input logic [7:0] b, input logic e);
        logic [CP_W-1:0] cp;
        logic            bad;
        t_seq_len        len;
        byte_results.delete();
        if (seq_len != SEQ_NONE && b[7:6] == 2'b10) begin
            if (held_n + 1 < int'(seq_len)) begin
                // more continuations to come, just hold this one
                held_b[held_n] = b;
                held_n++;
            end else begin
                case (seq_len)
                    SEQ_2: begin
                        cp  = {10'd0, held_b[0][4:0], b[5:0]};
                        bad = cp < CP_MIN_2;
                    end
                    SEQ_3: begin
                        cp  = {5'd0, held_b[0][3:0], held_b[1][5:0], b[5:0]};
                        bad = cp < CP_MIN_3 || (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
                    end
                    default: begin
                        cp  = {held_b[0][2:0], held_b[1][5:0], held_b[2][5:0], b[5:0]};
                        bad = cp < CP_MIN_4 || cp > CP_MAX;
                    end
                endcase
                // byte order mark is dropped only from the head of a string
                if (bad) begin
                    note_result(CP_REPLACEMENT, 1'b1);
                end else if (!(cp == CP_BOM && at_start)) begin
                    note_result(cp, 1'b0);
                end
                seq_len  = SEQ_NONE;
                held_n   = 0;
                at_start = 1'b0;
            end
        end else begin
            // a non-continuation breaks any pending sequence, then starts afresh
            if (seq_len != SEQ_NONE) flush_sequence();
            len = SEQ_NONE;
            casez (b)
                8'b110?????: len = SEQ_2;
                8'b1110????: len = SEQ_3;
                8'b11110???: len = SEQ_4;
                default: ;
            endcase
            if (!b[7]) begin
                note_result({13'd0, b}, 1'b0);
                at_start = 1'b0;
            end else if (len == SEQ_NONE) begin
                note_result(CP_REPLACEMENT, 1'b1);
                at_start = 1'b0;
            end else begin
                held_b[0] = b;
                held_n    = 1;
                seq_len   = len;
            end
        end
        if (e) begin
            if (seq_len != SEQ_NONE) flush_sequence();
            at_start = 1'b1;
        end
        if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
        foreach (byte_results[i]) cp_expected = {cp_expected, byte_results[i]};
    endfunction

    // offers one item, holds it until accepted, then predicts its results
    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_end   <= e;
        do @(posedge clk); while (!in_ready);
        decode_byte(b, e);
        bytes_sent++;
        if (e) strings_sent++;
    endtask

    // appends one character to str_bytes: mostly well-formed, some broken
    function automatic void add_char();
        int              sel;
        int              len;
        int              drop;
        logic [CP_W-1:0] cp;
        logic [7:0]      enc [4];
        sel  = $urandom_range(0, 99);
        drop = 0;
        if (sel < 8) begin
            str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
            return;
        end else if (sel < 30) begin
            len = 1;
            cp  = CP_W'(pick_edge(0, 'h7F));
        end else if (sel < 48) begin
            len = 2;
            cp  = CP_W'(pick_edge('h80, 'h7FF));
        end else if (sel < 66) begin
            len = 3;
            if ($urandom_range(0, 4) == 0) cp = CP_W'(pick_edge('hD800, 'hDFFF));
            else cp = CP_W'(pick_edge('h800, 'hFFFF));
        end else if (sel < 80) begin
            len = 4;
            cp  = CP_W'(pick_edge('h10000, 'h10FFFF));
        end else if (sel < 84) begin
            len = 3;
            cp  = CP_BOM;
        end else if (sel < 90) begin
            // overlong: a value short enough for a shorter form
            len = $urandom_range(2, 4);
            cp  = CP_W'(pick_edge(0, len == 2 ? 'h7F : (len == 3 ? 'h7FF : 'hFFFF)));
        end else if (sel < 94) begin
            len = 4;
            cp  = CP_W'(pick_edge('h110000, 'h1FFFFF));
        end else begin
            // truncated sequence: its last continuation bytes are left out
            len  = $urandom_range(2, 4);
            cp   = CP_W'($urandom_range('h80, 'h10FFFF));
            drop = $urandom_range(1, len - 1);
        end
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < len - drop; i++) str_bytes = {str_bytes, enc[i]};
    endfunction

    // byte order mark at the head of a string, a broken sequence, a cut-off string
    task automatic test_bom_and_breaks();
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    // ascii extremes and bytes that cannot start a sequence
    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // overlong, surrogate, genuine U+FFFD, top of range and just beyond it
    task automatic test_sequences();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBD, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // random strings of one to six characters, string end on the last byte
    task automatic test_random_strings();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < 70) begin
            steady = ($urandom_range(0, 3) == 0);
            str_bytes.delete();
            if ($urandom_range(0, 9) == 0) begin
                str_bytes = {str_bytes, 8'hEF, 8'hBB, 8'hBF};
            end
            repeat ($urandom_range(1, 6)) add_char();
            foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
        steady = 1'b0;
    endtask

    // receiver holds off while the sender streams, back to back, groups whose last byte gives four results
    task automatic test_output_stall();
        rx_hold = 150;
        steady  = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_byte(8'hF0, 1'b0);
            send_byte(8'h90, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'h41, i == 7);
        end
        steady = 1'b0;
    endtask

    // receiver: a fresh wait before each item, or the one long hold-off when asked
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compares each accepted result with the oldest prediction and counts input stalls
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n) begin
            if (in_valid && !in_ready) input_stalls++;
            if (out_valid && out_ready) begin
                if (cp_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got cp %h rep %b last %b",
                             $time, out_cp, out_rep, out_last);
                    errors++;
                end else begin
                    want = cp_expected.pop_front();
                    if (out_cp !== want.code_point) begin
                        $display("%0t: code_point expected %h, got %h",
                                 $time, want.code_point, out_cp);
                        errors++;
                    end
                    if (out_rep !== want.replaced) begin
                        $display("%0t: replaced expected %b, got %b",
                                 $time, want.replaced, out_rep);
                        errors++;
                    end
                    if (out_last !== want.last_of_run) begin
                        $display("%0t: last_of_run expected %b, got %b",
                                 $time, want.last_of_run, out_last);
                        errors++;
                    end
                    results_seen++;
                    if (want.replaced) subs_seen++;
                end
            end
        end
    end

    // main sequence: reset once, directed checks, random strings, output stall
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_bom_and_breaks();
        test_single_bytes();
        test_sequences();
        test_random_strings();
        test_output_stall();
        in_valid <= 1'b0;
        while (cp_expected.size() != 0) @(posedge clk);
        // a short drain after the queue empties catches any stray result
        repeat (16) @(posedge clk);
        $display("decoded %0d bytes in %0d strings into %0d code points, %0d substituted",
                 bytes_sent, strings_sent, results_seen, subs_seen);
        $display("input held off for %0d cycles by a full result queue", input_stalls);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", cp_expected.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/utf8d_pkg.sv
src/utf8d_decoder.sv
src/utf8d_result_fifo.sv
src/utf8_stream_decoder.sv
test/tb_top.sv
